// ===== sv/bcn_tbd_pkg.sv =====
// shared types, codes and arithmetic helpers of the bcn texture block decoder
`timescale 1ns / 1ps
`default_nettype none
package bcn_tbd_pkg;

  // format register codes
  localparam logic [2:0] FMT_BC1 = 3'd0;
  localparam logic [2:0] FMT_BC2 = 3'd1;
  localparam logic [2:0] FMT_BC3 = 3'd2;
  localparam logic [2:0] FMT_BC4 = 3'd3;
  localparam logic [2:0] FMT_BC5 = 3'd4;

  // configuration register indexes
  localparam logic REG_FORMAT = 1'b0;
  localparam logic REG_WIDTH  = 1'b1;

  localparam int unsigned CFG_DW = 13;
  localparam int unsigned PIX_W  = 24;

  // channel order inside a palette entry
  localparam int unsigned CH_R = 0;
  localparam int unsigned CH_G = 1;
  localparam int unsigned CH_B = 2;
  localparam int unsigned CH_A = 3;

  // one decoded block, ready for texel emission
  typedef struct packed {
    logic [2:0]             fmt;
    logic [3:0][3:0][7:0]   pal;   // [entry][channel]
    logic [31:0]            csel;  // 2-bit colour selectors
    logic [7:0][7:0]        ta;    // level table from the low word
    logic [7:0][7:0]        tb;    // level table from the high word
    logic [63:0]            alo;   // low word: explicit alpha or level indexes
    logic [47:0]            bidx;  // level indexes of the high word
    logic [PIX_W-1:0]       base;  // pixel index of the top-left texel
  } blk_t;

  // (v*527+23)>>6
  function automatic logic [7:0] exp5(input logic [4:0] v);
    logic [13:0] p;
    p = 14'(v) * 14'd527 + 14'd23;
    return p[13:6];
  endfunction

  // (v*259+33)>>6
  function automatic logic [7:0] exp6(input logic [5:0] v);
    logic [13:0] p;
    p = 14'(v) * 14'd259 + 14'd33;
    return p[13:6];
  endfunction

  // floor(x/3), exact for x < 2048
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd683;
    return p[18:11];
  endfunction

  // floor(x/7), exact for x < 5461
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd2341;
    return p[21:14];
  endfunction

  // floor(x/5), exact for x < 2730
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [21:0] p;
    p = 22'(x) * 22'd1639;
    return p[20:13];
  endfunction

  // 8-entry interpolated level table of a single-channel block
  function automatic logic [7:0][7:0] level_tab(input logic [7:0] a0, input logic [7:0] a1);
    logic [7:0][7:0] t;
    logic [10:0]     s;
    t    = '0;
    t[0] = a0;
    t[1] = a1;
    if (a0 > a1) begin
      for (int k = 1; k <= 6; k++) begin
        s        = 11'(7 - k) * 11'(a0) + 11'(k) * 11'(a1);
        t[k + 1] = div7(s);
      end
    end else begin
      for (int k = 1; k <= 4; k++) begin
        s        = 11'(5 - k) * 11'(a0) + 11'(k) * 11'(a1);
        t[k + 1] = div5(s);
      end
      t[6] = 8'h00;
      t[7] = 8'hFF;
    end
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== sv/bcn_tbd_front.sv =====
// front end: takes compressed blocks, expands endpoints and builds palettes and tables
`timescale 1ns / 1ps
`default_nettype none
module bcn_tbd_front
  import bcn_tbd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [11:0]       block_x_i,
  input  logic [11:0]       block_y_i,
  input  logic [63:0]       data_low_i,
  input  logic [63:0]       data_high_i,
  input  logic [2:0]        fmt_i,
  input  logic [CFG_DW-1:0] width_i,
  input  logic              full_i,
  output logic              push_o,
  output blk_t              push_data_o
);

  typedef struct packed {
    logic [2:0]       fmt;
    logic             three;  // bc1 three-colour mode
    logic [2:0][7:0]  e0;
    logic [2:0][7:0]  e1;
    logic [31:0]      csel;
    logic [63:0]      lo;
    logic [63:0]      hi;
    logic [PIX_W-1:0] base;
  } s1_t;

  s1_t  s1_q, s1_d;
  logic s1_valid_q, s1_valid_d;
  logic in_acc;

  logic [63:0] cb;
  logic [15:0] c0, c1;
  logic [24:0] row_prod;

  assign push_o     = s1_valid_q && !full_i;
  assign in_ready_o = !s1_valid_q || !full_i;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    cb       = (fmt_i == FMT_BC1) ? data_low_i : data_high_i;
    c0       = cb[15:0];
    c1       = cb[31:16];
    row_prod = 25'(block_y_i) * 25'(width_i);

    s1_d.fmt   = fmt_i;
    s1_d.three = (fmt_i == FMT_BC1) && !(c0 > c1);
    s1_d.e0[CH_R] = exp5(c0[15:11]);
    s1_d.e0[CH_G] = exp6(c0[10:5]);
    s1_d.e0[CH_B] = exp5(c0[4:0]);
    s1_d.e1[CH_R] = exp5(c1[15:11]);
    s1_d.e1[CH_G] = exp6(c1[10:5]);
    s1_d.e1[CH_B] = exp5(c1[4:0]);
    s1_d.csel  = cb[63:32];
    s1_d.lo    = data_low_i;
    s1_d.hi    = data_high_i;
    s1_d.base  = row_prod[PIX_W-1:0] + PIX_W'(block_x_i);
  end

  assign s1_valid_d = in_acc || (s1_valid_q && !push_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
  end

  // palette and level tables
  always_comb begin
    logic [9:0] s01, s10;
    logic [8:0] hsum;
    push_data_o = '0;
    for (int ch = 0; ch < 3; ch++) begin
      s01  = 10'({s1_q.e0[ch], 1'b0}) + 10'(s1_q.e1[ch]);
      s10  = 10'({s1_q.e1[ch], 1'b0}) + 10'(s1_q.e0[ch]);
      hsum = 9'(s1_q.e0[ch]) + 9'(s1_q.e1[ch]);
      push_data_o.pal[0][ch] = s1_q.e0[ch];
      push_data_o.pal[1][ch] = s1_q.e1[ch];
      push_data_o.pal[2][ch] = s1_q.three ? hsum[8:1] : div3(s01);
      push_data_o.pal[3][ch] = s1_q.three ? 8'h00 : div3(s10);
    end
    push_data_o.pal[0][CH_A] = 8'hFF;
    push_data_o.pal[1][CH_A] = 8'hFF;
    push_data_o.pal[2][CH_A] = 8'hFF;
    push_data_o.pal[3][CH_A] = s1_q.three ? 8'h00 : 8'hFF;
    push_data_o.fmt  = s1_q.fmt;
    push_data_o.csel = s1_q.csel;
    push_data_o.ta   = level_tab(s1_q.lo[7:0], s1_q.lo[15:8]);
    push_data_o.tb   = level_tab(s1_q.hi[7:0], s1_q.hi[15:8]);
    push_data_o.alo  = s1_q.lo;
    push_data_o.bidx = s1_q.hi[63:16];
    push_data_o.base = s1_q.base;
  end

endmodule
`default_nettype wire

// ===== sv/bcn_tbd_fifo.sv =====
// short queue of decoded blocks between front and back
`timescale 1ns / 1ps
`default_nettype none
module bcn_tbd_fifo
  import bcn_tbd_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  blk_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output blk_t head_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  blk_t          mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== sv/bcn_tbd_back.sv =====
// back end: walks the 16 texels of the head block and drives the output register
`timescale 1ns / 1ps
`default_nettype none
module bcn_tbd_back
  import bcn_tbd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  blk_t              head_i,
  output logic              pop_o,
  input  logic [CFG_DW-1:0] width_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        red_o,
  output logic [7:0]        green_o,
  output logic [7:0]        blue_o,
  output logic [7:0]        alpha_o,
  output logic [PIX_W-1:0]  pixel_index_o,
  output logic              last_o
);

  logic             valid_q, valid_d;
  logic [3:0]       cnt_q, cnt_d;
  logic [PIX_W-1:0] row_q, row_d;
  logic             load;

  logic [7:0]       r_d, g_d, b_d, a_d;
  logic [PIX_W-1:0] pix_d;
  logic [PIX_W-1:0] cur_row;
  logic [1:0]       sel;
  logic [5:0]       ia_pos, ib_pos;
  logic [2:0]       ia, ib;
  logic [3:0]       nib;

  assign load  = !empty_i && (!valid_q || out_ready_i);
  assign pop_o = load && (cnt_q == 4'd15);

  always_comb begin
    sel     = head_i.csel[{cnt_q, 1'b0} +: 2];
    ia_pos  = 6'd16 + 6'(cnt_q) * 6'd3;
    ib_pos  = 6'(cnt_q) * 6'd3;
    ia      = head_i.alo[ia_pos +: 3];
    ib      = head_i.bidx[ib_pos +: 3];
    nib     = head_i.alo[{cnt_q, 2'b00} +: 4];
    cur_row = (cnt_q == 4'd0) ? head_i.base : row_q;
    pix_d   = cur_row + PIX_W'(cnt_q[1:0]);

    r_d = 8'h00;
    g_d = 8'h00;
    b_d = 8'h00;
    a_d = 8'h00;
    unique case (head_i.fmt)
      FMT_BC1: begin
        r_d = head_i.pal[sel][CH_R];
        g_d = head_i.pal[sel][CH_G];
        b_d = head_i.pal[sel][CH_B];
        a_d = head_i.pal[sel][CH_A];
      end
      FMT_BC2: begin
        r_d = head_i.pal[sel][CH_R];
        g_d = head_i.pal[sel][CH_G];
        b_d = head_i.pal[sel][CH_B];
        a_d = {nib, nib};  // nibble times 17
      end
      FMT_BC3: begin
        r_d = head_i.pal[sel][CH_R];
        g_d = head_i.pal[sel][CH_G];
        b_d = head_i.pal[sel][CH_B];
        a_d = head_i.ta[ia];
      end
      FMT_BC4: begin
        r_d = head_i.ta[ia];
      end
      FMT_BC5: begin
        r_d = head_i.ta[ia];
        g_d = head_i.tb[ib];
      end
      default: begin
        r_d = 8'h00;
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    cnt_d   = cnt_q;
    row_d   = row_q;
    if (load) begin
      valid_d = 1'b1;
      cnt_d   = cnt_q + 4'd1;
      if (cnt_q[1:0] == 2'd3) begin
        row_d = cur_row + PIX_W'(width_i);  // next row of the block
      end else begin
        row_d = cur_row;
      end
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    if (load) begin
      red_o         <= r_d;
      green_o       <= g_d;
      blue_o        <= b_d;
      alpha_o       <= a_d;
      pixel_index_o <= pix_d;
      last_o        <= (cnt_q == 4'd15);
    end
  end

  assign out_valid_o = valid_q;

endmodule
`default_nettype wire

// ===== sv/bcn_texture_block_decoder_unit.sv =====
// top level of the bcn texture block decoder
//
// Decodes one BC1..BC5 compressed 4x4 block per input word into 16 texel words.
// Input channel: in_valid_i/in_ready_o with block_x_i, block_y_i (top-left texel)
// and the block bytes in data_low_i (bytes 0..7) and data_high_i (bytes 8..15).
// Output channel: out_valid_o/out_ready_i with red/green/blue/alpha, pixel_index_o
// ((block_y+row)*image_width + block_x + column, low 24 bits) and last_o on the
// sixteenth texel; texels come in row order.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 = format, 1 = image width) at a rising edge; the user must write only while
// the block is idle, which the block itself does not enforce.
// A block passes the front-end register and the queue before the back end loads its
// texels into the output register. Throughput: one texel per cycle unless the
// receiver stalls, set by the single texel output register the back end fills.
// The front end holds one block and the queue QUEUE_DEPTH decoded blocks, so new
// blocks are taken while earlier ones are still being emitted.
// Reset (rst_ni low, asynchronous) empties the pipeline and sets format to BC1 and
// image width to 4. A stalled receiver holds the output word; the queue then fills
// and in_ready_o drops.
`timescale 1ns / 1ps
`default_nettype none
module bcn_texture_block_decoder_unit
  import bcn_tbd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [11:0]       block_x_i,
  input  logic [11:0]       block_y_i,
  input  logic [63:0]       data_low_i,
  input  logic [63:0]       data_high_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        red_o,
  output logic [7:0]        green_o,
  output logic [7:0]        blue_o,
  output logic [7:0]        alpha_o,
  output logic [PIX_W-1:0]  pixel_index_o,
  output logic              last_o
);

  logic [2:0]        fmt_q;
  logic [CFG_DW-1:0] width_q;

  logic push, pop, full, empty;
  blk_t push_data, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   <= FMT_BC1;
      width_q <= CFG_DW'(4);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FORMAT: fmt_q   <= cfg_data_i[2:0];
        REG_WIDTH:  width_q <= cfg_data_i;
        default:    fmt_q   <= fmt_q;
      endcase
    end
  end

  bcn_tbd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .block_x_i   (block_x_i),
    .block_y_i   (block_y_i),
    .data_low_i  (data_low_i),
    .data_high_i (data_high_i),
    .fmt_i       (fmt_q),
    .width_i     (width_q),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  bcn_tbd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  bcn_tbd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .head_i        (head),
    .pop_o         (pop),
    .width_i       (width_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .alpha_o       (alpha_o),
    .pixel_index_o (pixel_index_o),
    .last_o        (last_o)
  );

endmodule
`default_nettype wire

// ===== sv/bcn_tbd_checker.sv =====
// port-level checks of the bcn texture block decoder, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module bcn_tbd_checker
  import bcn_tbd_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cfg_we_i,
  input logic              cfg_index_i,
  input logic [CFG_DW-1:0] cfg_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [7:0]        red_o,
  input logic [7:0]        green_o,
  input logic [7:0]        blue_o,
  input logic [7:0]        alpha_o,
  input logic [PIX_W-1:0]  pixel_index_o,
  input logic              last_o
);

  logic             out_acc;
  logic [3:0]       cnt_q;
  logic [PIX_W-1:0] pix_q;
  logic [2:0]       fmt_q;

  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      pix_q <= '0;
      fmt_q <= FMT_BC1;
    end else begin
      if (out_acc) begin
        cnt_q <= cnt_q + 4'd1;
        pix_q <= pixel_index_o;
      end
      if (cfg_we_i && (cfg_index_i == REG_FORMAT)) begin
        fmt_q <= cfg_data_i[2:0];
      end
    end
  end

  // a stalled output word stays and holds its pixel index, red, alpha and last mark
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_index_o)
      && $stable(red_o) && $stable(alpha_o) && $stable(last_o))
    else $error("output word changed while stalled");

  // last marks every sixteenth word exactly
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (last_o == (cnt_q == 4'd15)))
    else $error("last mark out of place");

  // within a block row the pixel index steps by one
  a_pix_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && (cnt_q[1:0] != 2'd0) |-> pixel_index_o == pix_q + 24'd1)
    else $error("pixel index did not advance along the row");

  // bc4 carries only the red channel
  a_bc4_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && (fmt_q == FMT_BC4) |-> green_o == 8'h00 && blue_o == 8'h00
      && alpha_o == 8'h00)
    else $error("bc4 word with nonzero unused channel");

endmodule

bind bcn_texture_block_decoder_unit bcn_tbd_checker u_bcn_tbd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .cfg_index_i   (cfg_index_i),
  .cfg_data_i    (cfg_data_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .red_o         (red_o),
  .green_o       (green_o),
  .blue_o        (blue_o),
  .alpha_o       (alpha_o),
  .pixel_index_o (pixel_index_o),
  .last_o        (last_o)
);
`default_nettype wire

// ===== test/bcn_texture_block_decoder_unit_test.sv =====
// self-checking testbench of the bcn texture block decoder top level
`timescale 1ns / 1ps
module bcn_texture_block_decoder_unit_test;
  import bcn_tbd_pkg::*;

  // format codes the decoder leaves undefined
  localparam logic [2:0] FMT_RSV5 = 3'd5;
  localparam logic [2:0] FMT_RSV6 = 3'd6;
  localparam logic [2:0] FMT_RSV7 = 3'd7;

  localparam int PHASES     = 14;
  localparam int QUIET_MAX  = 4000;
  localparam int SETTLE     = 20;
  localparam int HOLD_LEN   = 300;

  typedef struct packed {
    logic [11:0] bx;
    logic [11:0] by;
    logic [63:0] lo;
    logic [63:0] hi;
  } block_t;

  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic [PIX_W-1:0] pix;
    logic             last;
  } texel_t;

  typedef logic [3:0][3:0][7:0] palette_t;  // [entry][channel]
  typedef logic [7:0][7:0]      levels_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic              cfg_index_i = REG_FORMAT;
  logic [CFG_DW-1:0] cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [11:0]       block_x_i = '0;
  logic [11:0]       block_y_i = '0;
  logic [63:0]       data_low_i = '0;
  logic [63:0]       data_high_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [7:0]        red_o;
  logic [7:0]        green_o;
  logic [7:0]        blue_o;
  logic [7:0]        alpha_o;
  logic [PIX_W-1:0]  pixel_index_o;
  logic              last_o;

  bcn_texture_block_decoder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .block_x_i     (block_x_i),
    .block_y_i     (block_y_i),
    .data_low_i    (data_low_i),
    .data_high_i   (data_high_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .alpha_o       (alpha_o),
    .pixel_index_o (pixel_index_o),
    .last_o        (last_o)
  );

  always #6 clk_i = ~clk_i;

  // shadow of the configuration registers
  logic [2:0]  cfg_fmt = FMT_BC1;
  logic [12:0] cfg_width = 13'd4;

  block_t blocks_pending[$];
  texel_t texels_due[$];
  block_t offer;
  bit     offer_live = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_reqs = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned mismatches = 0;
  int unsigned quiet = 0;

  texel_t got;
  texel_t want;

  logic [2:0]  phase_fmt [PHASES] = '{FMT_BC1, FMT_BC2, FMT_BC3, FMT_BC4, FMT_BC5,
                                       FMT_RSV5, FMT_RSV6, FMT_RSV7, FMT_BC5, FMT_BC1,
                                       FMT_BC4, FMT_BC3, FMT_BC2, FMT_BC1};
  logic [12:0] phase_width [PHASES] = '{13'd4, 13'd4096, 13'd8191, 13'd0, 13'd640,
                                         13'd5, 13'd1, 13'd4, 13'd8, 13'd1024,
                                         13'd4092, 13'd3, 13'd12, 13'd16};

  function automatic logic [7:0] widen5(logic [4:0] v);
    int unsigned t;
    t = 32'(v);
    t = (t * 527 + 23) >> 6;
    return t[7:0];
  endfunction

  function automatic logic [7:0] widen6(logic [5:0] v);
    int unsigned t;
    t = 32'(v);
    t = (t * 259 + 33) >> 6;
    return t[7:0];
  endfunction

  function automatic palette_t colour_palette(logic [63:0] blk, bit three_ok);
    logic [15:0] c0, c1;
    int unsigned e0[3], e1[3];
    palette_t    p;
    bit          punch;
    int          ch;
    c0 = blk[15:0];
    c1 = blk[31:16];
    e0[CH_R] = 32'(widen5(c0[15:11]));
    e0[CH_G] = 32'(widen6(c0[10:5]));
    e0[CH_B] = 32'(widen5(c0[4:0]));
    e1[CH_R] = 32'(widen5(c1[15:11]));
    e1[CH_G] = 32'(widen6(c1[10:5]));
    e1[CH_B] = 32'(widen5(c1[4:0]));
    punch = three_ok && (c0 <= c1);
    p = '0;
    for (ch = 0; ch < 3; ch++) begin
      p[0][ch] = e0[ch][7:0];
      p[1][ch] = e1[ch][7:0];
      if (!punch) begin
        p[2][ch] = 8'((2 * e0[ch] + e1[ch]) / 3);
        p[3][ch] = 8'((2 * e1[ch] + e0[ch]) / 3);
      end else begin
        p[2][ch] = 8'((e0[ch] + e1[ch]) / 2);
        p[3][ch] = 8'h00;
      end
    end
    p[0][CH_A] = 8'hFF;
    p[1][CH_A] = 8'hFF;
    p[2][CH_A] = 8'hFF;
    p[3][CH_A] = punch ? 8'h00 : 8'hFF;
    return p;
  endfunction

  function automatic levels_t level_set(logic [63:0] blk);
    int unsigned a0, a1, k;
    levels_t     t;
    a0 = 32'(blk[7:0]);
    a1 = 32'(blk[15:8]);
    t = '0;
    t[0] = a0[7:0];
    t[1] = a1[7:0];
    if (a0 > a1) begin
      for (k = 1; k <= 6; k++) t[k + 1] = 8'(((7 - k) * a0 + k * a1) / 7);
    end else begin
      for (k = 1; k <= 4; k++) t[k + 1] = 8'(((5 - k) * a0 + k * a1) / 5);
      t[6] = 8'h00;
      t[7] = 8'hFF;
    end
    return t;
  endfunction

  // expands one accepted block into its sixteen texels
  function automatic void decode_block(block_t b);
    palette_t        pal;
    levels_t         la, lb;
    logic [63:0]     cb;
    logic [1:0]      sel;
    texel_t          t;
    longint unsigned pix;
    int unsigned     i, row, col;
    cb  = (cfg_fmt == FMT_BC1) ? b.lo : b.hi;
    pal = colour_palette(cb, cfg_fmt == FMT_BC1);
    la  = level_set(b.lo);
    lb  = level_set(b.hi);
    for (i = 0; i < 16; i++) begin
      t   = '0;
      row = i >> 2;
      col = i & 3;
      sel = cb[32 + 2 * i +: 2];
      case (cfg_fmt)
        FMT_BC1, FMT_BC2, FMT_BC3: begin
          t.red   = pal[sel][CH_R];
          t.green = pal[sel][CH_G];
          t.blue  = pal[sel][CH_B];
          t.alpha = pal[sel][CH_A];
          if (cfg_fmt == FMT_BC2) t.alpha = 8'(b.lo[4 * i +: 4] * 17);
          else if (cfg_fmt == FMT_BC3) t.alpha = la[b.lo[16 + 3 * i +: 3]];
        end
        FMT_BC4: t.red = la[b.lo[16 + 3 * i +: 3]];
        FMT_BC5: begin
          t.red   = la[b.lo[16 + 3 * i +: 3]];
          t.green = lb[b.hi[16 + 3 * i +: 3]];
        end
        default: ;
      endcase
      pix = 64'(b.by);
      pix = (pix + row) * cfg_width + b.bx + col;
      t.pix  = pix[PIX_W-1:0];
      t.last = (i == 15);
      texels_due.push_back(t);
    end
  endfunction

  // steers a word toward one of the endpoint orderings
  function automatic logic [63:0] shape_endpoints(logic [63:0] w);
    case ($urandom_range(6))
      1: if (w[15:0] < w[31:16]) w[31:0] = {w[15:0], w[31:16]};
      2: if (w[15:0] > w[31:16]) w[31:0] = {w[15:0], w[31:16]};
      3: if (w[7:0] < w[15:8]) w[15:0] = {w[7:0], w[15:8]};
      4: if (w[7:0] > w[15:8]) w[15:0] = {w[7:0], w[15:8]};
      5: w[31:16] = w[15:0];
      6: w[15:8] = w[7:0];
      default: ;
    endcase
    return w;
  endfunction

  function automatic block_t random_block();
    block_t b;
    if ($urandom_range(3) == 0) begin
      b.bx = 12'($urandom_range(4095));
      b.by = 12'($urandom_range(4095));
    end else begin
      b.bx = 12'($urandom_range(63) * 4);
      b.by = 12'($urandom_range(63) * 4);
    end
    b.lo = shape_endpoints({$urandom, $urandom});
    b.hi = shape_endpoints({$urandom, $urandom});
    return b;
  endfunction

  function automatic string texel_text(texel_t t);
    return $sformatf("r %02h g %02h b %02h a %02h pix %0d last %0b",
                     t.red, t.green, t.blue, t.alpha, t.pix, t.last);
  endfunction

  task automatic flag_mismatch(string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  task automatic write_reg(logic idx, logic [CFG_DW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_FORMAT) cfg_fmt = val[2:0];
    else cfg_width = val;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (blocks_pending.size() != 0 || offer_live || texels_due.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // block driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        decode_block(offer);
        offer_live = 1'b0;
      end
      if (!offer_live) begin
        if (blocks_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offer      = blocks_pending.pop_front();
          offer_live = 1'b1;
          in_valid_i  <= 1'b1;
          block_x_i   <= offer.bx;
          block_y_i   <= offer.by;
          data_low_i  <= offer.lo;
          data_high_i <= offer.hi;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // texel monitor and receiver back-pressure
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.red   = red_o;
        got.green = green_o;
        got.blue  = blue_o;
        got.alpha = alpha_o;
        got.pix   = pixel_index_o;
        got.last  = last_o;
        if (texels_due.size() == 0) begin
          flag_mismatch({"unexpected texel: ", texel_text(got)});
        end else begin
          want = texels_due.pop_front();
          if (got !== want)
            flag_mismatch({"got ", texel_text(got), " want ", texel_text(want)});
        end
      end
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= QUIET_MAX) begin
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  initial begin
    int     p, n;
    block_t b;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(negedge clk_i);
    for (p = 0; p < PHASES; p++) begin
      // phase 0 runs on the reset values
      if (p != 0) begin
        write_reg(REG_FORMAT, {10'($urandom), phase_fmt[p]});
        write_reg(REG_WIDTH, phase_width[p]);
      end
      @(negedge clk_i);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      // receiver blocked for a long stretch while blocks keep coming
      if (p == 4) hold_reqs++;
      case (p)
        0: begin
          blocks_pending.push_back('{12'd0, 12'd0, 64'h0, 64'h0});
          blocks_pending.push_back('{12'hFFF, 12'hFFF, '1, '1});
          blocks_pending.push_back('{12'd4, 12'd0, {32'hE4E4_E4E4, 16'h001F, 16'hF800}, 64'h0});
          blocks_pending.push_back('{12'd0, 12'd4, {32'hE4E4_E4E4, 16'hF800, 16'h001F}, 64'h0});
          blocks_pending.push_back('{12'd8, 12'd8, {32'h1B1B_E4E4, 16'h7BEF, 16'h7BEF}, '1});
          blocks_pending.push_back('{12'd4092, 12'd4092, {32'h4E4E_B1B1, 16'hFFFF, 16'h0000},
                                     64'h0});
        end
        1: begin
          blocks_pending.push_back('{12'd0, 12'd0, 64'hFEDC_BA98_7654_3210,
                                     {32'hE4E4_E4E4, 16'hF800, 16'h001F}});
          blocks_pending.push_back('{12'd4092, 12'd4092, 64'h0123_4567_89AB_CDEF,
                                     {32'h1B1B_1B1B, 16'h07E0, 16'h07E0}});
        end
        2: begin
          blocks_pending.push_back('{12'd0, 12'd0, {48'hFAC688_FAC688, 8'h10, 8'hF0},
                                     {32'hE4E4_E4E4, 16'h001F, 16'hF800}});
          blocks_pending.push_back('{12'd4, 12'd4, {48'hFAC688_FAC688, 8'hF0, 8'h10},
                                     {32'hE4E4_E4E4, 16'hF800, 16'h001F}});
          blocks_pending.push_back('{12'hFFF, 12'hFFF, {48'h053977_053977, 8'h80, 8'h80},
                                     {32'h0, 16'hFFFF, 16'hFFFF}});
        end
        3: begin
          blocks_pending.push_back('{12'd0, 12'd0, {48'hFAC688_FAC688, 8'h00, 8'hFF}, '1});
          blocks_pending.push_back('{12'd8, 12'd12, {48'hFAC688_FAC688, 8'hFF, 8'h00}, '1});
        end
        4: begin
          blocks_pending.push_back('{12'd0, 12'd0, {48'hFAC688_FAC688, 8'h10, 8'hF0},
                                     {48'h053977_053977, 8'hC0, 8'h20}});
          blocks_pending.push_back('{12'd636, 12'd4, {48'hFAC688_FAC688, 8'h20, 8'hC0},
                                     {48'hFAC688_FAC688, 8'hF0, 8'h10}});
        end
        5, 6, 7: blocks_pending.push_back('{12'hFFF, 12'hFFF, '1, '1});
        default: ;
      endcase
      n = (phase_fmt[p] > FMT_BC5) ? 6 : 35;
      repeat (n) begin
        b = random_block();
        blocks_pending.push_back(b);
      end
      wait_drained();
    end
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bcn_tbd_pkg.sv
sv/bcn_tbd_front.sv
sv/bcn_tbd_fifo.sv
sv/bcn_tbd_back.sv
sv/bcn_texture_block_decoder_unit.sv
sv/bcn_tbd_checker.sv
test/bcn_texture_block_decoder_unit_test.sv
